>>> src/oaids_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array package
// Shared constants, codes and types for the ordered array insert, delete and
// search unit.
// ----------------------------------------------------------------------------
package oaids_pkg;

   localparam int DEPTH = 32;
   localparam int DATA_W = 32;
   localparam int POS_W = 6;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADPOS   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic                     do_insert;
      logic                     do_delete;
      logic                     do_search;
      logic                     do_read;
      logic [CMP_W-1:0]         position;
      logic [CMP_W-1:0]         count;
      logic signed [DATA_W-1:0] value;
   } ctrl_type;

endpackage

>>> src/oaids_cell.sv
// ----------------------------------------------------------------------------
// Ordered array cell
// Holds one entry, takes a neighbor's entry on insert or delete, and flags a
// key match or a read hit for its own slot.
// ----------------------------------------------------------------------------
module oaids_cell
   import oaids_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_type                 ctrl,
   input  logic [CMP_W-1:0]         slot,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data,
   output logic                     match,
   output logic                     hit
);

   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     match_ff, match_in;
   logic                     hit_ff, hit_in;
   logic [CMP_W-1:0]         slot_one;

   assign slot_one = slot + CMP_W'(1);

   always_comb begin
      data_in = data_ff;
      if (ctrl.do_insert) begin
         if (slot_one == ctrl.position) begin
            data_in = ctrl.value;
         end else if (slot_one > ctrl.position) begin
            data_in = left_data;
         end
      end else if (ctrl.do_delete) begin
         if (slot_one >= ctrl.position) begin
            data_in = right_data;
         end
      end
      match_in = ctrl.do_search && (slot < ctrl.count) && (data_ff == ctrl.value);
      hit_in = ctrl.do_read && (slot_one == ctrl.position);
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
         hit_ff <= hit_in;
      end
   end

   assign data = data_ff;
   assign match = match_ff;
   assign hit = hit_ff;

endmodule

>>> src/oaids_pick.sv
// ----------------------------------------------------------------------------
// Ordered array result picker
// Finds the first matching cell and selects the entry of the cell that was
// addressed by a read.
// ----------------------------------------------------------------------------
module oaids_pick
   import oaids_pkg::*;
(
   input  logic [DEPTH-1:0]         match,
   input  logic [DEPTH-1:0]         hit,
   input  logic signed [DATA_W-1:0] data [DEPTH],
   output logic                     any_match,
   output logic [CMP_W-1:0]         first_position,
   output logic signed [DATA_W-1:0] read_data
);

   always_comb begin
      first_position = '0;
      read_data = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            first_position = CMP_W'(i + 1);
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         read_data = read_data | (hit[i] ? data[i] : '0);
      end
   end

   assign any_match = |match;

endmodule

>>> src/ordered_array_insert_delete_search_unit.sv
// ----------------------------------------------------------------------------
// Ordered array insert, delete and search unit
// Keeps an ordered list of signed entries in a row of cells and runs insert,
// delete, search and read transactions on it.
// ----------------------------------------------------------------------------
// In each transaction the cells shift or compare in the cycle of the accepting
// edge, and the result is shown with rsp_valid high in the following cycle,
// during which busy is high, so no new transaction is accepted. The result
// is on the rsp_ ports for that one cycle only, and the receiver must take it
// then. Positions are 1-based; rsp_count is the number of entries after the
// transaction.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_search_unit
   import oaids_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_command,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [POS_W-1:0]         rsp_found_position,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [POS_W-1:0]         rsp_count
);

   logic                     busy_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   op_type                   op_ff;
   status_type               status_ff, status_in;
   logic                     accept;
   op_type                   op;
   logic [CMP_W-1:0]         pos;
   logic [CMP_W-1:0]         cnt;
   ctrl_type                 ctrl;
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]         match;
   logic [DEPTH-1:0]         hit;
   logic                     any_match;
   logic [CMP_W-1:0]         first_position;
   logic signed [DATA_W-1:0] read_data;
   status_type               status_out;

   assign accept = start && !busy_ff;
   assign op = op_type'(req_command);
   assign pos = CMP_W'(req_position);
   assign cnt = CMP_W'(count_ff);

   always_comb begin
      status_in = ST_OK;
      count_in = count_ff;
      ctrl = '0;
      ctrl.position = pos;
      ctrl.count = cnt;
      ctrl.value = req_value;
      unique case (op)
         OP_INSERT: begin
            if (cnt == CMP_W'(DEPTH)) begin
               status_in = ST_FULL;
            end else if (pos == '0 || pos > cnt + CMP_W'(1)) begin
               status_in = ST_BADPOS;
            end else begin
               ctrl.do_insert = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (pos == '0 || pos > cnt) begin
               status_in = ST_BADPOS;
            end else begin
               ctrl.do_delete = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_SEARCH: begin
            ctrl.do_search = accept;
         end
         OP_READ: begin
            if (pos == '0 || pos > cnt) begin
               status_in = ST_BADPOS;
            end else begin
               ctrl.do_read = accept;
            end
         end
         default: begin
            status_in = ST_BADPOS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
         op_ff <= OP_INSERT;
         status_ff <= ST_OK;
      end else begin
         busy_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
            op_ff <= op;
            status_ff <= status_in;
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      oaids_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .slot       (CMP_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .match      (match[i]),
         .hit        (hit[i])
      );
   end

   oaids_pick u_pick (
      .match          (match),
      .hit            (hit),
      .data           (cell_data),
      .any_match      (any_match),
      .first_position (first_position),
      .read_data      (read_data)
   );

   always_comb begin
      status_out = status_ff;
      if (op_ff == OP_SEARCH) begin
         status_out = any_match ? ST_OK : ST_NOTFOUND;
      end
   end

   assign busy = busy_ff;
   assign rsp_valid = busy_ff;
   assign rsp_status = status_out;
   assign rsp_found_position = (op_ff == OP_SEARCH && any_match) ?
                               POS_W'(first_position) : '0;
   assign rsp_read_value = (op_ff == OP_READ && status_ff == ST_OK) ? read_data : '0;
   assign rsp_count = POS_W'(count_ff);

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("Accepted transaction did not produce a result.");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result shown for more than one cycle.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Entry count exceeds the array depth.");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_position != '0 |-> rsp_status == ST_OK)
      else $error("Found position reported with an error status.");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_INSERT && status_in == ST_OK |=>
      count_ff == $past(count_ff) + CNT_W'(1))
      else $error("Successful insert did not raise the entry count.");

endmodule

>>> tb/ordered_array_insert_delete_search_unit_test.sv
// ----------------------------------------------------------------------------
// Ordered array insert, delete and search unit testbench
// Sends directed and random insert, delete, search and read transactions
// through the start and busy handshake. A tracker class keeps its own copy of
// the array, works out each expected result and compares every result field.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_search_unit_test;
   import oaids_pkg::*;

   localparam int N_RANDOM = 1625;
   localparam int N_QUIET = 200;
   localparam int STALL_LIMIT = 400;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      status_type               status;
      logic [POS_W-1:0]         found_position;
      logic signed [DATA_W-1:0] read_value;
      logic [POS_W-1:0]         count;
   } outcome_type;

   class array_tracker;
      logic signed [DATA_W-1:0] cells[DEPTH];
      int live_count;
      int failures;
      outcome_type pending_outcomes[$];

      function new();
         live_count = 0;
         failures = 0;
         foreach (cells[i]) cells[i] = '0;
      endfunction

      function void note_command(op_type cmd, int pos, logic signed [DATA_W-1:0] value);
         outcome_type want;
         int i;
         want.status = ST_OK;
         want.found_position = '0;
         want.read_value = '0;
         case (cmd)
            OP_INSERT: begin
               if (live_count >= DEPTH) begin
                  want.status = ST_FULL;
               end else if (pos < 1 || pos > live_count + 1) begin
                  want.status = ST_BADPOS;
               end else begin
                  for (i = live_count; i > pos - 1; i--) cells[i] = cells[i - 1];
                  cells[pos - 1] = value;
                  live_count++;
               end
            end
            OP_DELETE: begin
               if (pos < 1 || pos > live_count) begin
                  want.status = ST_BADPOS;
               end else begin
                  for (i = pos - 1; i + 1 < live_count; i++) cells[i] = cells[i + 1];
                  live_count--;
               end
            end
            OP_SEARCH: begin
               want.status = ST_NOTFOUND;
               for (i = 0; i < live_count; i++) begin
                  if (want.status == ST_NOTFOUND && cells[i] == value) begin
                     want.status = ST_OK;
                     want.found_position = POS_W'(i + 1);
                  end
               end
            end
            default: begin
               if (pos < 1 || pos > live_count) begin
                  want.status = ST_BADPOS;
               end else begin
                  want.read_value = cells[pos - 1];
               end
            end
         endcase
         want.count = POS_W'(live_count);
         pending_outcomes.push_back(want);
      endfunction

      function void check_outcome(logic [1:0] status, logic [POS_W-1:0] found,
                                  logic signed [DATA_W-1:0] rd, logic [POS_W-1:0] cnt);
         outcome_type want;
         if (pending_outcomes.size() == 0) begin
            $error("result with no transaction outstanding: status %0d count %0d",
                   status, cnt);
            failures++;
            return;
         end
         want = pending_outcomes.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (found !== want.found_position) begin
            $error("found_position: expected %0d, actual %0d", want.found_position, found);
            failures++;
         end
         if (rd !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, rd);
            failures++;
         end
         if (cnt !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, cnt);
            failures++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_command;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic [POS_W-1:0]         rsp_found_position;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [POS_W-1:0]         rsp_count;

   array_tracker tracker;
   int stalled = 0;

   ordered_array_insert_delete_search_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_read_value     (rsp_read_value),
      .rsp_count          (rsp_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            tracker.note_command(op_type'(req_command), int'(req_position), req_value);
         end
         if (rsp_valid) begin
            tracker.check_outcome(rsp_status, rsp_found_position, rsp_read_value, rsp_count);
         end
         if ((start && !busy) || rsp_valid) begin
            stalled = 0;
         end else begin
            stalled++;
         end
         if (stalled >= STALL_LIMIT) begin
            $display("ordered_array_insert_delete_search_unit: mismatch");
            $finish;
         end
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      int sel;
      int near;
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
         near = $urandom_range(0, 7) - 3;
         return near;
      end else if (sel == 3) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      return $urandom();
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send(op_type cmd, int pos, logic signed [DATA_W-1:0] value, bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) begin
            req_command <= 2'($urandom());
            req_position <= POS_W'($urandom());
            req_value <= $urandom();
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_command <= cmd;
      req_position <= POS_W'(pos);
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_directed();
      send(OP_READ, 1, 32'sd7, 1'b1);
      send(OP_DELETE, 1, 32'sd0, 1'b1);
      send(OP_SEARCH, 0, 32'sd0, 1'b1);
      send(OP_INSERT, 0, 32'sd5, 1'b1);
      send(OP_INSERT, 2, 32'sd5, 1'b1);
      send(OP_INSERT, 1, 32'sh7fff_ffff, 1'b1);
      send(OP_INSERT, 1, 32'sh8000_0000, 1'b1);
      send(OP_INSERT, 3, 32'sd0, 1'b1);
      send(OP_INSERT, 2, -32'sd1, 1'b1);
      send(OP_INSERT, 5, 32'sh7fff_ffff, 1'b1);
      send(OP_SEARCH, 63, 32'sh7fff_ffff, 1'b1);
      send(OP_SEARCH, 0, 32'sh8000_0000, 1'b1);
      send(OP_SEARCH, 1, 32'sd12345, 1'b1);
      send(OP_READ, 5, -32'sd1, 1'b1);
      send(OP_READ, 0, 32'sd0, 1'b1);
      send(OP_READ, 6, 32'sd0, 1'b1);
      send(OP_READ, 63, 32'sd0, 1'b1);
      send(OP_DELETE, 0, 32'sd0, 1'b1);
      send(OP_DELETE, 6, 32'sd0, 1'b1);
      send(OP_INSERT, 63, 32'sd9, 1'b1);
      send(OP_DELETE, 2, 32'sd0, 1'b1);
      send(OP_DELETE, 4, 32'sd0, 1'b1);
      send(OP_READ, 1, 32'sd0, 1'b1);
   endtask

   // Alternates between filling and draining the array so that the full and
   // empty corners are reached many times.
   task automatic run_random();
      bit growing;
      int k;
      int n;
      int sel;
      int pos;
      op_type cmd;
      logic signed [DATA_W-1:0] value;
      growing = 1'b1;
      for (k = 0; k < N_RANDOM; k++) begin
         n = tracker.live_count;
         if (n == DEPTH && $urandom_range(0, 7) == 0) begin
            growing = 1'b0;
         end else if (n == 0 && $urandom_range(0, 3) == 0) begin
            growing = 1'b1;
         end else if ($urandom_range(0, 63) == 0) begin
            growing = !growing;
         end
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            cmd = growing ? OP_INSERT : OP_DELETE;
         end else if (sel < 70) begin
            cmd = growing ? OP_DELETE : OP_INSERT;
         end else if (sel < 85) begin
            cmd = OP_SEARCH;
         end else begin
            cmd = OP_READ;
         end
         value = pick_value();
         if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, 63);
         end else if (cmd == OP_INSERT) begin
            pos = $urandom_range(1, n + 1);
         end else begin
            pos = $urandom_range(1, (n > 0) ? n : 1);
         end
         if (cmd == OP_SEARCH && n > 0 && $urandom_range(0, 2) != 0) begin
            value = tracker.cells[$urandom_range(0, n - 1)];
         end
         send(cmd, pos, value, k < N_RANDOM - N_QUIET);
      end
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      start = 1'b0;
      req_command = '0;
      req_position = '0;
      req_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      start <= 1'b0;
      while (tracker.pending_outcomes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("ordered_array_insert_delete_search_unit: match");
      end else begin
         $display("ordered_array_insert_delete_search_unit: mismatch");
      end
      $finish;
   end

endmodule
